// ===== src/art_pkg.sv =====
// shared types and codes for the address range region table
// used by every module of the block and by its checker
package art_pkg;

   localparam int ADDRESS_BITS = 48;
   localparam int TAG_BITS = 8;
   localparam int TABLE_ENTRIES_DEFAULT = 16;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_DUP = 2'd3;

   typedef struct packed {
      logic [1:0] operation;
      logic [ADDRESS_BITS-1:0] address;
      logic [ADDRESS_BITS-1:0] region_size;
      logic [TAG_BITS-1:0] region_tag;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [ADDRESS_BITS-1:0] found_base;
      logic [ADDRESS_BITS-1:0] found_size;
      logic [TAG_BITS-1:0] found_tag;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic match_found;
      logic free_found;
      logic best_found;
      logic [ADDRESS_BITS-1:0] best_base;
      logic [ADDRESS_BITS-1:0] best_len;
      logic [TAG_BITS-1:0] best_tag;
   } token_type;

   typedef struct packed {
      logic write;
      logic clear;
      logic [ADDRESS_BITS-1:0] base;
      logic [ADDRESS_BITS-1:0] len;
      logic [TAG_BITS-1:0] tag;
   } commit_type;

   typedef enum logic [1:0] {
      ART_IDLE,
      ART_WALK,
      ART_RESP
   } state_type;

endpackage

// ===== src/address_range_region_table.sv =====
// address range region table: a row of TABLE_ENTRIES slot cells walked by a search token
// the search token is registered in each cell in turn, and the response is registered in art_finish
// one transaction at a time, set by the walk along the row:
// the next request is taken in the cycle after the response leaves
// synchronous reset empties the table at once; no clearing pass
module address_range_region_table #(
   parameter int TABLE_ENTRIES = art_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  art_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output art_pkg::rsp_type rsp_payload
);

   localparam int IDX_BITS = $clog2(TABLE_ENTRIES);

   art_pkg::state_type state_ff, state_in;
   logic req_take;
   logic tvalid [0:TABLE_ENTRIES];
   art_pkg::token_type tok [0:TABLE_ENTRIES];
   logic [IDX_BITS-1:0] midx [0:TABLE_ENTRIES];
   logic [IDX_BITS-1:0] fidx [0:TABLE_ENTRIES];
   art_pkg::commit_type commit;
   logic [IDX_BITS-1:0] commit_idx;

   assign req_take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         art_pkg::ART_IDLE: begin
            if (req_valid) state_in = art_pkg::ART_WALK;
         end
         art_pkg::ART_WALK: begin
            if (tvalid[TABLE_ENTRIES]) state_in = art_pkg::ART_RESP;
         end
         art_pkg::ART_RESP: begin
            if (!rsp_stall) state_in = art_pkg::ART_IDLE;
         end
         default: begin
            state_in = art_pkg::ART_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         art_pkg::ART_IDLE: req_stall = 1'b0;
         art_pkg::ART_RESP: rsp_valid = 1'b1;
         default: begin
            req_stall = 1'b1;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= art_pkg::ART_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      tvalid[0] = req_take;
      tok[0] = '0;
      tok[0].req = req_payload;
      midx[0] = '0;
      fidx[0] = '0;
   end

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      art_cell #(
         .TABLE_ENTRIES(TABLE_ENTRIES),
         .CELL_INDEX(g)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .up_valid(tvalid[g]),
         .up_tok(tok[g]),
         .up_midx(midx[g]),
         .up_fidx(fidx[g]),
         .commit(commit),
         .commit_idx(commit_idx),
         .dn_valid(tvalid[g+1]),
         .dn_tok(tok[g+1]),
         .dn_midx(midx[g+1]),
         .dn_fidx(fidx[g+1])
      );
   end

   art_finish #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_finish (
      .clock(clock),
      .tail_valid(tvalid[TABLE_ENTRIES]),
      .tail_tok(tok[TABLE_ENTRIES]),
      .tail_midx(midx[TABLE_ENTRIES]),
      .tail_fidx(fidx[TABLE_ENTRIES]),
      .commit(commit),
      .commit_idx(commit_idx),
      .rsp_payload(rsp_payload)
   );

endmodule

// ===== src/art_cell.sv =====
// one table slot: holds a region and updates the passing search token
// depends on art_pkg
module art_cell #(
   parameter int TABLE_ENTRIES = art_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int CELL_INDEX = 0,
   localparam int IDX_BITS = $clog2(TABLE_ENTRIES)
) (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   input  art_pkg::token_type up_tok,
   input  logic [IDX_BITS-1:0] up_midx,
   input  logic [IDX_BITS-1:0] up_fidx,
   input  art_pkg::commit_type commit,
   input  logic [IDX_BITS-1:0] commit_idx,
   output logic dn_valid,
   output art_pkg::token_type dn_tok,
   output logic [IDX_BITS-1:0] dn_midx,
   output logic [IDX_BITS-1:0] dn_fidx
);

   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_INDEX);

   logic valid_ff, valid_in;
   logic [art_pkg::ADDRESS_BITS-1:0] base_ff, len_ff;
   logic [art_pkg::TAG_BITS-1:0] tag_ff;
   logic tvalid_ff;
   art_pkg::token_type tok_ff, tok_in;
   logic [IDX_BITS-1:0] midx_ff, midx_in, fidx_ff, fidx_in;
   logic hit_me;

   assign hit_me = (commit_idx == MY_IDX);

   always_comb begin
      valid_in = valid_ff;
      if (commit.write && hit_me) begin
         valid_in = 1'b1;
      end else if (commit.clear && hit_me) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      tok_in = up_tok;
      midx_in = up_midx;
      fidx_in = up_fidx;
      if (valid_ff && base_ff == up_tok.req.address && !up_tok.match_found) begin
         tok_in.match_found = 1'b1;
         midx_in = MY_IDX;
      end
      if (!valid_ff && !up_tok.free_found) begin
         tok_in.free_found = 1'b1;
         fidx_in = MY_IDX;
      end
      if (valid_ff && base_ff <= up_tok.req.address &&
          (!up_tok.best_found || base_ff > up_tok.best_base)) begin
         tok_in.best_found = 1'b1;
         tok_in.best_base = base_ff;
         tok_in.best_len = len_ff;
         tok_in.best_tag = tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tvalid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tvalid_ff <= up_valid;
      end
      if (commit.write && hit_me) begin
         base_ff <= commit.base;
         len_ff <= commit.len;
         tag_ff <= commit.tag;
      end
      if (up_valid) begin
         tok_ff <= tok_in;
         midx_ff <= midx_in;
         fidx_ff <= fidx_in;
      end
   end

   assign dn_valid = tvalid_ff;
   assign dn_tok = tok_ff;
   assign dn_midx = midx_ff;
   assign dn_fidx = fidx_ff;

endmodule

// ===== src/art_finish.sv =====
// end of the cell row: decides status, issues the table update, holds the response
// depends on art_pkg
module art_finish #(
   parameter int TABLE_ENTRIES = art_pkg::TABLE_ENTRIES_DEFAULT,
   localparam int IDX_BITS = $clog2(TABLE_ENTRIES)
) (
   input  logic clock,
   input  logic tail_valid,
   input  art_pkg::token_type tail_tok,
   input  logic [IDX_BITS-1:0] tail_midx,
   input  logic [IDX_BITS-1:0] tail_fidx,
   output art_pkg::commit_type commit,
   output logic [IDX_BITS-1:0] commit_idx,
   output art_pkg::rsp_type rsp_payload
);

   art_pkg::rsp_type rsp_ff, rsp_in;
   logic [art_pkg::ADDRESS_BITS:0] limit;
   logic hit;

   assign limit = {1'b0, tail_tok.best_base} + {1'b0, tail_tok.best_len};
   assign hit = tail_tok.req.address != '0 && tail_tok.best_found &&
                {1'b0, tail_tok.req.address} < limit;

   always_comb begin
      rsp_in = '0;
      rsp_in.status = art_pkg::ST_MISS;
      commit = '0;
      commit.base = tail_tok.req.address;
      commit.len = tail_tok.req.region_size;
      commit.tag = tail_tok.req.region_tag;
      commit_idx = tail_fidx;
      case (tail_tok.req.operation)
         art_pkg::OP_INSERT: begin
            if (tail_tok.match_found) begin
               rsp_in.status = art_pkg::ST_DUP;
            end else if (tail_tok.free_found) begin
               rsp_in.status = art_pkg::ST_OK;
               commit.write = tail_valid;
            end else begin
               rsp_in.status = art_pkg::ST_FULL;
            end
         end
         art_pkg::OP_REMOVE: begin
            commit_idx = tail_midx;
            if (tail_tok.match_found) begin
               rsp_in.status = art_pkg::ST_OK;
               commit.clear = tail_valid;
            end
         end
         art_pkg::OP_LOOKUP: begin
            if (hit) begin
               rsp_in.status = art_pkg::ST_OK;
               rsp_in.found_base = tail_tok.best_base;
               rsp_in.found_size = tail_tok.best_len;
               rsp_in.found_tag = tail_tok.best_tag;
            end
         end
         default: begin
            rsp_in.status = art_pkg::ST_MISS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tail_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== src/art_checker.sv =====
// port-level checks of the address range region table, bound to the top level
// depends on art_pkg
module art_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input art_pkg::req_type req_payload,
   input logic rsp_valid,
   input logic rsp_stall,
   input art_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response too soon after request");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != art_pkg::ST_OK |->
         rsp_payload.found_base == '0 && rsp_payload.found_size == '0 &&
         rsp_payload.found_tag == '0)
      else $error("found fields nonzero without hit");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind address_range_region_table art_checker u_art_checker (.*);
